// ----- src/ptsa_pkg.sv -----
package ptsa_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int ADDR_W = $clog2(TABLE_ENTRIES);
	localparam int IDX_W = ((ADDR_W > 11) ? ADDR_W : 11) + 1;

	localparam int PAGE_W = 10;
	localparam int FRAME_W = 20;
	localparam int COUNT_W = 11;
	localparam int FLAGS_W = 12;
	localparam int ENTRY_W = FRAME_W + FLAGS_W;

	localparam logic [PAGE_W-1:0] DEFAULT_START_RST = 10'd512;

	localparam logic [1:0] KIND_MAP = 2'd0;
	localparam logic [1:0] KIND_PROTECT = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_FIND = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NO_SPAN = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic [COUNT_W-1:0] count;
		logic [FLAGS_W-1:0] page_flags;
	} ptsa_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] span_start;
	} ptsa_rsp_t;

	typedef struct packed {
		ptsa_req_t         item;
		logic [PAGE_W-1:0] start;
	} ptsa_cmd_t;

endpackage

// ----- src/ptsa_engine.sv -----
module ptsa_engine import ptsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  ptsa_cmd_t cmd,
	output logic      res_valid,
	input  logic      res_take,
	output ptsa_rsp_t res
);

	localparam logic [2:0] S_WIPE = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_PROT_RD = 3'd3;
	localparam logic [2:0] S_PROT_WR = 3'd4;
	localparam logic [2:0] S_FIND = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	localparam logic [IDX_W-1:0] ENTRIES_I = IDX_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_I = IDX_W'(TABLE_ENTRIES - 1);

	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] run_q;
	logic [IDX_W-1:0]   run_at_q;
	logic [FRAME_W-1:0] frame_q;
	logic [FLAGS_W-1:0] flags_q;
	logic               is_map_q;
	logic [1:0]         status_q;
	logic [PAGE_W-1:0]  span_q;
	logic [ENTRY_W-1:0] rd_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   pos_s1;

	logic               in_range;
	logic               mem_we;
	logic [ENTRY_W-1:0] mem_wd;
	logic [ADDR_W-1:0]  mem_addr;
	logic [COUNT_W-1:0] run_inc;
	logic               hit_zero;
	logic [IDX_W-1:0]   start_i;
	logic [IDX_W-1:0]   page_i;

	assign in_range = idx_q < ENTRIES_I;
	assign mem_addr = idx_q[ADDR_W-1:0];
	assign run_inc = run_q + COUNT_W'(1);
	assign hit_zero = rd_q == '0;
	assign start_i = IDX_W'(cmd.start);
	assign page_i = IDX_W'(cmd.item.page);

	assign mem_we = (state_q == S_WIPE) || (state_q == S_WALK && in_range)
		|| (state_q == S_PROT_WR);

	always_comb begin
		mem_wd = '0;
		if (state_q == S_WALK && is_map_q) begin
			mem_wd = {frame_q, flags_q};
		end else if (state_q == S_PROT_WR) begin
			mem_wd = {rd_q[ENTRY_W-1:FLAGS_W], flags_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		rd_q <= mem[mem_addr];
	end

	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res.status = status_q;
	assign res.span_start = span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			idx_q <= '0;
			vld_s1 <= 1'b0;
			cnt_q <= '0;
			run_q <= '0;
			run_at_q <= '0;
			frame_q <= '0;
			flags_q <= '0;
			is_map_q <= 1'b0;
			status_q <= ST_DONE;
			span_q <= '0;
			pos_s1 <= '0;
		end else begin
			unique case (state_q)
				S_WIPE: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == LAST_I) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (cmd_valid) begin
						frame_q <= cmd.item.frame;
						flags_q <= cmd.item.page_flags;
						is_map_q <= cmd.item.kind == KIND_MAP;
						cnt_q <= cmd.item.count;
						run_q <= '0;
						status_q <= ST_DONE;
						span_q <= '0;
						case (cmd.item.kind)
							KIND_MAP, KIND_CLEAR: begin
								idx_q <= page_i;
								state_q <= (cmd.item.count == '0) ? S_DONE : S_WALK;
							end
							KIND_PROTECT: begin
								idx_q <= page_i;
								if (page_i < ENTRIES_I) begin
									state_q <= S_PROT_RD;
								end else begin
									status_q <= ST_DROPPED;
									state_q <= S_DONE;
								end
							end
							default: begin
								idx_q <= start_i;
								if (cmd.item.count == '0) begin
									span_q <= cmd.start;
									state_q <= S_DONE;
								end else if (start_i < ENTRIES_I) begin
									state_q <= S_FIND;
								end else begin
									status_q <= ST_NO_SPAN;
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_WALK: begin
					idx_q <= idx_q + IDX_W'(1);
					frame_q <= frame_q + FRAME_W'(1);
					cnt_q <= cnt_q - COUNT_W'(1);
					if (!in_range) begin
						status_q <= ST_DROPPED;
						state_q <= S_DONE;
					end else if (cnt_q == COUNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_PROT_RD: begin
					state_q <= S_PROT_WR;
				end
				S_PROT_WR: begin
					state_q <= S_DONE;
				end
				S_FIND: begin
					vld_s1 <= in_range;
					pos_s1 <= idx_q;
					if (in_range) begin
						idx_q <= idx_q + IDX_W'(1);
					end
					if (vld_s1) begin
						if (!hit_zero) begin
							run_q <= '0;
						end else begin
							run_q <= run_inc;
							if (run_q == '0) begin
								run_at_q <= pos_s1;
							end
						end
						if (hit_zero && run_inc == cnt_q) begin
							span_q <= (run_q == '0) ? pos_s1[PAGE_W-1:0]
								: run_at_q[PAGE_W-1:0];
							vld_s1 <= 1'b0;
							state_q <= S_DONE;
						end else if (pos_s1 == LAST_I) begin
							status_q <= ST_NO_SPAN;
							vld_s1 <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_find_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIND |-> !mem_we)
		else $error("table written during span search");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> idx_q < ENTRIES_I)
		else $error("table write beyond last entry");

	a_fail_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_NO_SPAN |-> res.span_start == '0)
		else $error("failed search reports a span");

	a_take_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> state_q == S_IDLE)
		else $error("engine did not return to idle after transfer");

	a_found_span_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIND && vld_s1 && run_inc == cnt_q && hit_zero
		|=> state_q == S_DONE && status_q == ST_DONE)
		else $error("completed span not reported");

endmodule

// ----- src/page_table_span_allocator_unit.sv -----
// Page table of 1024 32-bit entries (frame in bits 31..12, flags in 11..0) with map, protect,
// clear and first-fit free-span search, one request in flight at a time. After reset a
// clearing pass zeroes every table entry with req_stall high. A map or clear of count
// pages writes those entries in turn, a protect reads one entry and writes it back with
// new flags, and a find reads entries in turn from its start page. Map, clear and find walk
// the table memory at one entry per cycle through its single read-write port. The next
// request is taken while a result still waits on rsp_stall.
module page_table_span_allocator_unit import ptsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ptsa_req_t         req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ptsa_rsp_t         rsp,
	input  logic              cfg_we,
	input  logic [PAGE_W-1:0] cfg_wdata
);

	logic [PAGE_W-1:0] default_start_q;
	logic              rsp_valid_q;
	ptsa_rsp_t         rsp_q;

	logic      cmd_ready;
	ptsa_cmd_t cmd;
	logic      res_valid;
	logic      res_take;
	ptsa_rsp_t res;

	assign cmd.item = req;
	assign cmd.start = (req.page == '0) ? default_start_q : req.page;

	ptsa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (req_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign req_stall = !cmd_ready;
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_start_q <= DEFAULT_START_RST;
		end else if (cfg_we) begin
			default_start_q <= cfg_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
